/* hw/rtl/assert_macros.svh */
// assertion macros shared by the rtl files
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define GRC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define GRC_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define GRC_ASSERT(label, clk, rst_n, prop, msg)

`define GRC_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

/* hw/rtl/grc_pkg.sv */
// shared constants, register indexes and types of the grid ray caster
// no dependencies
package grc_pkg;

  localparam int MAX_ROWS   = 256;
  localparam int MAX_COLS   = 256;
  localparam int MAX_WALK   = 512;
  localparam int GRID_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W     = $clog2(GRID_DEPTH);
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int COL_W      = $clog2(MAX_COLS);

  localparam int DIM_W      = 9;
  localparam int CNT_W      = 10;
  localparam int DELTA_W    = 12;
  localparam int COORD_W    = 13;
  localparam int ERR_W      = 16;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_DATA_W = 10;
  localparam int CFG_IDX_W  = 3;

  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);

  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_ROW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_COL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OCC_THR   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CELLS = 3'd5;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_CAST  = 1'b1;

  localparam logic signed [7:0] UNKNOWN_CELL = -8'sd1;

  typedef struct packed {
    logic [DIM_W-1:0]  grid_rows;
    logic [DIM_W-1:0]  grid_cols;
    logic [7:0]        start_row;
    logic [7:0]        start_col;
    logic signed [7:0] occ_limit;
    logic [CNT_W-1:0]  max_cells;
  } grc_cfg_t;

  // one queued item: a cell write or a cast already split into major/minor axes
  typedef struct packed {
    logic                      kind;
    logic [15:0]               cell_address;
    logic signed [7:0]         cell_value;
    logic                      steep;
    logic                      neg_x;
    logic                      neg_y;
    logic [7:0]                x0;
    logic [7:0]                y0;
    logic signed [DELTA_W-1:0] x1;
    logic [DELTA_W-1:0]        dmaj;
    logic [DELTA_W-1:0]        dmin;
  } grc_item_t;

endpackage

/* hw/rtl/grc_front.sv */
// front end: takes input transfers and classifies casts into bresenham set-up
// depends on grc_pkg
module grc_front import grc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic                 in_tuser,
  input  grc_cfg_t             cfg,
  output logic                 item_vld,
  input  logic                 item_rdy,
  output grc_item_t            item
);

  logic                      stg_vld_r;
  grc_item_t                 item_r;
  grc_item_t                 item_nxt;
  logic signed [DELTA_W-1:0] t_row;
  logic signed [DELTA_W-1:0] t_col;
  logic signed [COORD_W-1:0] dx;
  logic signed [COORD_W-1:0] dy;
  logic signed [COORD_W-1:0] ndx;
  logic signed [COORD_W-1:0] ndy;
  logic [DELTA_W-1:0]        adx;
  logic [DELTA_W-1:0]        ady;
  logic                      steep;

  assign in_tready = !stg_vld_r || item_rdy;
  assign item_vld  = stg_vld_r;
  assign item      = item_r;

  assign t_row = $signed(in_tdata[35:24]);
  assign t_col = $signed(in_tdata[47:36]);
  assign dx    = {t_col[DELTA_W-1], t_col} - $signed({5'b0, cfg.start_col});
  assign dy    = {t_row[DELTA_W-1], t_row} - $signed({5'b0, cfg.start_row});
  assign ndx   = -dx;
  assign ndy   = -dy;
  assign adx   = dx[COORD_W-1] ? ndx[DELTA_W-1:0] : dx[DELTA_W-1:0];
  assign ady   = dy[COORD_W-1] ? ndy[DELTA_W-1:0] : dy[DELTA_W-1:0];
  assign steep = ady >= adx;

  always_comb begin
    item_nxt.kind         = in_tuser;
    item_nxt.cell_address = in_tdata[15:0];
    item_nxt.cell_value   = $signed(in_tdata[23:16]);
    item_nxt.steep        = steep;
    if (steep) begin
      item_nxt.x0    = cfg.start_row;
      item_nxt.y0    = cfg.start_col;
      item_nxt.x1    = t_row;
      item_nxt.neg_x = dy[COORD_W-1];
      item_nxt.neg_y = dx[COORD_W-1];
      item_nxt.dmaj  = ady;
      item_nxt.dmin  = adx;
    end else begin
      item_nxt.x0    = cfg.start_col;
      item_nxt.y0    = cfg.start_row;
      item_nxt.x1    = t_col;
      item_nxt.neg_x = dx[COORD_W-1];
      item_nxt.neg_y = dy[COORD_W-1];
      item_nxt.dmaj  = adx;
      item_nxt.dmin  = ady;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else if (in_tready) begin
      stg_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= item_nxt;
    end
  end

endmodule

/* hw/rtl/grc_queue.sv */
// short item queue between the front end and the ray walker
// depends on grc_pkg
module grc_queue import grc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_vld,
  output logic      push_rdy,
  input  grc_item_t push_item,
  output logic      pop_vld,
  input  logic      pop_rdy,
  output grc_item_t pop_item
);

  grc_item_t          ent_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_PTR_W:0]   fill_r;
  logic               do_push;
  logic               do_pop;

  assign push_rdy = fill_r != (Q_PTR_W + 1)'(Q_DEPTH);
  assign pop_vld  = fill_r != '0;
  assign pop_item = ent_r[rd_ptr_r];
  assign do_push  = push_vld && push_rdy;
  assign do_pop   = pop_vld && pop_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* hw/rtl/grc_back.sv */
// back end: grid memory, bresenham walker and result register
// depends on grc_pkg and assert_macros.svh
`include "assert_macros.svh"

module grc_back import grc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  grc_cfg_t              cfg,
  input  logic                  pop_vld,
  output logic                  pop_rdy,
  input  grc_item_t             pop_item,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // end_row, end_col, cells_walked, zero fill
  output logic                  out_tuser   // hit
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_DONE = 3'b100
  } walk_state_t;

  walk_state_t state_r;
  walk_state_t state_nxt;

  logic [7:0] mem [GRID_DEPTH];

  logic signed [COORD_W-1:0] x_r;
  logic signed [COORD_W-1:0] y_r;
  logic signed [COORD_W-1:0] x1_r;
  logic                      steep_r;
  logic                      negx_r;
  logic                      negy_r;
  logic signed [ERR_W-1:0]   e_r;
  logic signed [ERR_W-1:0]   inc_a_r;
  logic signed [ERR_W-1:0]   inc_b_r;
  logic [CNT_W-1:0]          iss_cnt_r;
  logic                      chk_vld_r;
  logic [ROW_W-1:0]          chk_row_r;
  logic [COL_W-1:0]          chk_col_r;
  logic [CNT_W-1:0]          chk_cnt_r;
  logic signed [7:0]         rd_data_r;
  logic                      hit_r;
  logic [7:0]                end_row_r;
  logic [7:0]                end_col_r;
  logic [CNT_W-1:0]          cnt_r;
  logic                      out_vld_r;
  logic                      out_hit_r;
  logic [7:0]                out_row_r;
  logic [7:0]                out_col_r;
  logic [CNT_W-1:0]          out_cnt_r;

  logic [DIM_W-1:0]          rows_sat;
  logic [DIM_W-1:0]          cols_sat;
  logic [CNT_W-1:0]          lim;
  logic signed [COORD_W-1:0] r_cur;
  logic signed [COORD_W-1:0] c_cur;
  logic                      off_map;
  logic                      stop_iss;
  logic                      val_hit;
  logic [ROW_W+DIM_W-1:0]    prod;
  logic [ADDR_W-1:0]         rd_addr;
  logic                      mem_we;
  logic                      start_cast;
  logic                      out_free;
  logic signed [ERR_W-1:0]   dmin2;
  logic signed [ERR_W-1:0]   dmaj1;
  logic signed [ERR_W-1:0]   dmaj2;

  assign rows_sat = (cfg.grid_rows > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : cfg.grid_rows;
  assign cols_sat = (cfg.grid_cols > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : cfg.grid_cols;
  assign lim      = (cfg.max_cells > CNT_W'(MAX_WALK)) ? CNT_W'(MAX_WALK) : cfg.max_cells;

  assign r_cur   = steep_r ? x_r : y_r;
  assign c_cur   = steep_r ? y_r : x_r;
  assign off_map = r_cur < 0 || c_cur < 0
                || r_cur >= $signed({{(COORD_W-DIM_W){1'b0}}, rows_sat})
                || c_cur >= $signed({{(COORD_W-DIM_W){1'b0}}, cols_sat});
  assign stop_iss = (x_r == x1_r) || off_map || (iss_cnt_r >= lim);
  assign val_hit  = chk_vld_r && (rd_data_r > cfg.occ_limit
                                  || rd_data_r == UNKNOWN_CELL);

  assign prod    = (ROW_W + DIM_W)'(r_cur[ROW_W-1:0]) * (ROW_W + DIM_W)'(cols_sat);
  assign rd_addr = ADDR_W'(prod + (ROW_W + DIM_W)'(c_cur[COL_W-1:0]));

  assign pop_rdy    = state_r == S_IDLE;
  assign start_cast = pop_rdy && pop_vld && pop_item.kind == KIND_CAST;
  assign mem_we     = pop_rdy && pop_vld && pop_item.kind == KIND_WRITE
                   && {1'b0, pop_item.cell_address} < 17'(GRID_DEPTH);
  assign out_free   = !out_vld_r || out_tready;

  assign dmin2 = $signed({3'b0, pop_item.dmin, 1'b0});
  assign dmaj1 = $signed({4'b0, pop_item.dmaj});
  assign dmaj2 = $signed({3'b0, pop_item.dmaj, 1'b0});

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start_cast) begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (val_hit || stop_iss) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[pop_item.cell_address[ADDR_W-1:0]] <= pop_item.cell_value;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= $signed(mem[rd_addr]);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      chk_vld_r <= 1'b0;
      iss_cnt_r <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (start_cast) begin
        chk_vld_r <= 1'b0;
        iss_cnt_r <= '0;
      end else if (state_r == S_WALK) begin
        if (val_hit || stop_iss) begin
          chk_vld_r <= 1'b0;
        end else begin
          chk_vld_r <= 1'b1;
          iss_cnt_r <= iss_cnt_r + 1'b1;
        end
      end
      if (state_r == S_DONE && out_free) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // walk datapath
  always_ff @(posedge clk) begin
    if (start_cast) begin
      x_r       <= $signed({5'b0, pop_item.x0});
      y_r       <= $signed({5'b0, pop_item.y0});
      x1_r      <= {pop_item.x1[DELTA_W-1], pop_item.x1};
      steep_r   <= pop_item.steep;
      negx_r    <= pop_item.neg_x;
      negy_r    <= pop_item.neg_y;
      e_r       <= dmin2 - dmaj1;
      inc_a_r   <= dmin2 - dmaj2;
      inc_b_r   <= dmin2;
      hit_r     <= 1'b0;
      end_row_r <= cfg.start_row;
      end_col_r <= cfg.start_col;
      cnt_r     <= '0;
    end else if (state_r == S_WALK) begin
      if (chk_vld_r) begin
        end_row_r <= 8'(chk_row_r);
        end_col_r <= 8'(chk_col_r);
        cnt_r     <= chk_cnt_r;
      end
      if (val_hit) begin
        hit_r <= 1'b1;
      end else if (!stop_iss) begin
        chk_row_r <= r_cur[ROW_W-1:0];
        chk_col_r <= c_cur[COL_W-1:0];
        chk_cnt_r <= iss_cnt_r + 1'b1;
        x_r       <= negx_r ? x_r - 13'sd1 : x_r + 13'sd1;
        if (e_r > 0) begin
          e_r <= e_r + inc_a_r;
          y_r <= negy_r ? y_r - 13'sd1 : y_r + 13'sd1;
        end else begin
          e_r <= e_r + inc_b_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_hit_r <= hit_r;
      out_row_r <= end_row_r;
      out_col_r <= end_col_r;
      out_cnt_r <= cnt_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_hit_r;
  assign out_tdata  = {(OUT_DATA_W - CNT_W - 16)'(0), out_cnt_r, out_col_r, out_row_r};

  `GRC_ASSERT(a_chk_in_walk, clk, rst_n, chk_vld_r |-> state_r == S_WALK, "cell check outside walk")
  `GRC_ASSERT(a_cnt_limit, clk, rst_n, state_r == S_WALK |-> iss_cnt_r <= lim, "walk count beyond limit")
  `GRC_ASSERT(a_chk_cnt, clk, rst_n, chk_vld_r |-> chk_cnt_r == iss_cnt_r, "check count out of step")
  `GRC_ASSERT(a_out_from_done, clk, rst_n, $rose(out_vld_r) |-> $past(state_r == S_DONE), "result without finished walk")

endmodule

/* hw/rtl/grid_ray_caster.sv */
// grid ray caster top level: configuration registers, front end, queue, walker
// depends on grc_pkg, grc_front, grc_queue, grc_back
//
// Items are cell writes (tuser 0) or ray casts (tuser 1). The front end takes one
// transfer per cycle while its four-entry queue has room. In the walker a cast runs
// through a set-up step, one grid cell read per cell, a test of the last cell read and
// the posting of the result; it walks at most max_cells cells and never more than 512.
// The walk rate is set by the single grid memory: the read of the next cell overlaps
// the occupancy test of the previous one. Casts produce one result each, writes none.
// Configuration writes must only happen while no item is in flight.
module grid_ray_caster import grc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // cell_address, cell_value, target_row, target_col
  input  logic                  in_tuser,   // kind
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // end_row, end_col, cells_walked, zero fill
  output logic                  out_tuser   // hit
);

  grc_cfg_t  cfg_r;
  logic      fr_vld;
  logic      fr_rdy;
  grc_item_t fr_item;
  logic      q_vld;
  logic      q_rdy;
  grc_item_t q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grid_rows <= DIM_W'(MAX_ROWS);
      cfg_r.grid_cols <= DIM_W'(MAX_COLS);
      cfg_r.start_row <= 8'd128;
      cfg_r.start_col <= 8'd128;
      cfg_r.occ_limit <= 8'sd50;
      cfg_r.max_cells <= CNT_W'(MAX_WALK);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_GRID_ROWS: cfg_r.grid_rows <= cfg_wdata[DIM_W-1:0];
        REG_GRID_COLS: cfg_r.grid_cols <= cfg_wdata[DIM_W-1:0];
        REG_START_ROW: cfg_r.start_row <= cfg_wdata[7:0];
        REG_START_COL: cfg_r.start_col <= cfg_wdata[7:0];
        REG_OCC_THR:   cfg_r.occ_limit <= $signed(cfg_wdata[7:0]);
        REG_MAX_CELLS: cfg_r.max_cells <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  grc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg       (cfg_r),
    .item_vld  (fr_vld),
    .item_rdy  (fr_rdy),
    .item      (fr_item)
  );

  grc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_vld  (fr_vld),
    .push_rdy  (fr_rdy),
    .push_item (fr_item),
    .pop_vld   (q_vld),
    .pop_rdy   (q_rdy),
    .pop_item  (q_item)
  );

  grc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .pop_vld    (q_vld),
    .pop_rdy    (q_rdy),
    .pop_item   (q_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
